// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LPE_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define LPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/lpe_pkg.sv =====
// Shared types, constants and helpers of the line position estimator.
// No dependencies; used by lpe_front, lpe_fifo, lpe_back and the top level.
package lpe_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int CHAN_W       = 4;
  localparam int MAG_W        = 12;
  localparam int WEIGHT_W     = MAG_W + 1;
  localparam int SUM_W        = 17;
  localparam int CNT_W        = 4;
  localparam int ERR_W        = 13;
  localparam int PREV_W       = 14;
  localparam int PRESET_W     = 13;
  localparam int NUM_SENSORS  = 14;
  localparam int HALF_SENSORS = 7;
  localparam int NUM_REGS     = HALF_SENSORS + 1;
  localparam int REG_IDX_W    = 3;

  localparam logic [CNT_W-1:0] MAX_HITS = 4'hF;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAG0      = 3'd1;

  // Divide by five as multiply by ceil(2^18/5) and shift; exact below 2^18.
  localparam int               RECIP5_SHIFT = 18;
  localparam logic [15:0]      RECIP5       = 16'd52429;

  typedef enum logic [1:0] {
    LOST_NONE = 2'b00,
    LOST_POS  = 2'b01,
    LOST_NEG  = 2'b11
  } lost_t;

  typedef logic [HALF_SENSORS-1:0][MAG_W-1:0] mag_arr_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    mag_arr_t            mag;
  } cfg_t;

  // One classified sample as it travels from front to back.
  typedef struct packed {
    logic                       hit;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       frame_end;
  } q_entry_t;

  // 6/5 of a magnitude, truncated.
  function automatic logic [PRESET_W-1:0] preset_mag(input logic [MAG_W-1:0] m);
    logic [14:0] x6;
    logic [30:0] prod;
    x6   = {1'b0, m, 2'b00} + {2'b00, m, 1'b0};
    prod = {16'd0, x6} * {15'd0, RECIP5};
    return prod[RECIP5_SHIFT +: PRESET_W];
  endfunction

endpackage

// ===== rtl/lpe_front.sv =====
// Front end: takes samples, compares against the threshold and looks up
// the signed channel weight. Depends on lpe_pkg.
module lpe_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpe_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [lpe_pkg::CHAN_W-1:0]    in_channel,
  input  logic                          in_frame_end,
  input  lpe_pkg::cfg_t                 cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output lpe_pkg::q_entry_t             q_wdata
);

  logic                               chan_ok;
  logic                               lower_half;
  logic [2:0]                         mag_idx;
  logic [lpe_pkg::MAG_W-1:0]          mag_sel;
  logic signed [lpe_pkg::WEIGHT_W-1:0] weight;

  assign chan_ok    = in_channel < lpe_pkg::CHAN_W'(lpe_pkg::NUM_SENSORS);
  assign lower_half = in_channel < lpe_pkg::CHAN_W'(lpe_pkg::HALF_SENSORS);

  // Invalid channels fall back to entry 0; they never count as hits.
  always_comb begin
    if (!chan_ok) begin
      mag_idx = 3'd0;
    end else if (lower_half) begin
      mag_idx = in_channel[2:0];
    end else begin
      mag_idx = 3'(in_channel - lpe_pkg::CHAN_W'(lpe_pkg::HALF_SENSORS));
    end
  end

  assign mag_sel = cfg.mag[mag_idx];
  assign weight  = lower_half ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});

  assign in_stall          = q_full;
  assign q_push            = in_valid && !q_full;
  assign q_wdata.hit       = chan_ok && (in_sample > cfg.threshold);
  assign q_wdata.weight    = weight;
  assign q_wdata.frame_end = in_frame_end;

endmodule

// ===== rtl/lpe_fifo.sv =====
// Short register queue between front and back end.
// Depends on lpe_pkg for the entry type.
module lpe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpe_pkg::q_entry_t wdata,
  input  logic              pop,
  output lpe_pkg::q_entry_t rdata,
  output logic              full,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpe_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_nxt;

  assign full  = cnt_r == CW'(DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lpe_back.sv =====
// Back end: accumulates classified samples, divides sum by count with a
// bit-serial divider, tracks line loss and holds the result register.
// Depends on lpe_pkg.
module lpe_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lpe_pkg::cfg_t                      cfg,
  input  logic                               q_empty,
  input  lpe_pkg::q_entry_t                  q_rdata,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lpe_pkg::ERR_W-1:0]   out_line_error,
  output logic [lpe_pkg::CNT_W-1:0]          out_active_count,
  output logic signed [1:0]                  out_lost_side,
  output logic                               out_restart_timer
);

  localparam int DIV_W  = lpe_pkg::SUM_W - 1;
  localparam int STEP_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                                state_r;
  logic signed [lpe_pkg::SUM_W-1:0]      acc_sum_r;
  logic [lpe_pkg::CNT_W-1:0]             acc_cnt_r;
  logic [DIV_W-1:0]                      div_quo_r;
  logic [lpe_pkg::CNT_W-1:0]             div_rem_r;
  logic [lpe_pkg::CNT_W-1:0]             div_den_r;
  logic                                  div_neg_r;
  logic [STEP_W-1:0]                     div_step_r;
  lpe_pkg::lost_t                        lost_r;
  logic signed [lpe_pkg::PREV_W-1:0]     prev_err_r;
  logic [lpe_pkg::PRESET_W-1:0]          preset_neg_r;
  logic [lpe_pkg::PRESET_W-1:0]          preset_pos_r;
  logic                                  out_valid_r;
  logic signed [lpe_pkg::ERR_W-1:0]      out_err_r;
  logic [lpe_pkg::CNT_W-1:0]             out_cnt_r;
  logic [1:0]                            out_lost_r;
  logic                                  out_restart_r;

  logic                                  take;
  logic signed [lpe_pkg::SUM_W-1:0]      sum_nxt;
  logic [lpe_pkg::CNT_W-1:0]             cnt_nxt;
  logic signed [lpe_pkg::SUM_W-1:0]      sum_abs;
  logic [lpe_pkg::CNT_W:0]               rem_shift;
  logic                                  rem_ge;
  logic [lpe_pkg::CNT_W:0]               rem_sub;
  logic [lpe_pkg::ERR_W-1:0]             err_mag;
  logic signed [lpe_pkg::ERR_W-1:0]      err_val;
  logic                                  fin_load;
  logic signed [lpe_pkg::PREV_W-1:0]     neg_mag3;
  logic signed [lpe_pkg::PREV_W-1:0]     pos_mag1;
  lpe_pkg::lost_t                        lost_nxt;
  logic signed [lpe_pkg::PREV_W-1:0]     prev_nxt;
  logic                                  restart_nxt;

  // Accumulate: hits past fifteen are dropped.
  assign take    = q_rdata.hit && (acc_cnt_r != lpe_pkg::MAX_HITS);
  assign sum_nxt = acc_sum_r + (take ?
                   {{(lpe_pkg::SUM_W - lpe_pkg::WEIGHT_W){q_rdata.weight[lpe_pkg::WEIGHT_W-1]}},
                    q_rdata.weight} : lpe_pkg::SUM_W'(0));
  assign cnt_nxt = acc_cnt_r + lpe_pkg::CNT_W'(take);
  assign sum_abs = sum_nxt[lpe_pkg::SUM_W-1] ? -sum_nxt : sum_nxt;

  assign q_pop = (state_r == ST_ACC) && !q_empty;

  // One restoring-division step per cycle.
  assign rem_shift = {div_rem_r, div_quo_r[DIV_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_den_r};
  assign rem_sub   = rem_shift - {1'b0, div_den_r};

  assign err_mag = {1'b0, div_quo_r[lpe_pkg::ERR_W-2:0]};
  assign err_val = (div_den_r == '0) ? '0 :
                   (div_neg_r ? -$signed(err_mag) : $signed(err_mag));

  assign neg_mag3 = -$signed({2'b00, cfg.mag[3]});
  assign pos_mag1 = $signed({2'b00, cfg.mag[1]});

  always_comb begin
    lost_nxt    = lost_r;
    prev_nxt    = prev_err_r;
    restart_nxt = 1'b0;
    if (div_den_r != '0) begin
      lost_nxt = lpe_pkg::LOST_NONE;
      if (lost_r == lpe_pkg::LOST_NEG) begin
        restart_nxt = 1'b1;
        prev_nxt    = -$signed({1'b0, preset_neg_r});
      end else if (lost_r == lpe_pkg::LOST_POS) begin
        restart_nxt = 1'b1;
        prev_nxt    = $signed({1'b0, preset_pos_r});
      end else begin
        prev_nxt = {{(lpe_pkg::PREV_W - lpe_pkg::ERR_W){err_val[lpe_pkg::ERR_W-1]}}, err_val};
      end
    end else if (prev_err_r < neg_mag3) begin
      lost_nxt = lpe_pkg::LOST_NEG;
    end else if (prev_err_r > pos_mag1) begin
      lost_nxt = lpe_pkg::LOST_POS;
    end
  end

  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // Presets track magnitudes; user changes configuration only while idle.
  always_ff @(posedge clk) begin
    preset_neg_r <= lpe_pkg::preset_mag(cfg.mag[0]);
    preset_pos_r <= lpe_pkg::preset_mag(cfg.mag[lpe_pkg::HALF_SENSORS-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      acc_sum_r   <= '0;
      acc_cnt_r   <= '0;
      lost_r      <= lpe_pkg::LOST_NONE;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
      div_den_r   <= '0;
      div_step_r  <= '0;
    end else begin
      // Load a finished frame, or drop the held result once transferred.
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_ACC: begin
          if (q_pop) begin
            if (q_rdata.frame_end) begin
              acc_sum_r  <= '0;
              acc_cnt_r  <= '0;
              div_den_r  <= cnt_nxt;
              div_neg_r  <= sum_nxt[lpe_pkg::SUM_W-1];
              div_quo_r  <= sum_abs[DIV_W-1:0];
              div_rem_r  <= '0;
              div_step_r <= '0;
              state_r    <= (cnt_nxt == '0) ? ST_FIN : ST_DIV;
            end else begin
              acc_sum_r <= sum_nxt;
              acc_cnt_r <= cnt_nxt;
            end
          end
        end
        ST_DIV: begin
          div_rem_r  <= rem_ge ? rem_sub[lpe_pkg::CNT_W-1:0] : rem_shift[lpe_pkg::CNT_W-1:0];
          div_quo_r  <= {div_quo_r[DIV_W-2:0], rem_ge};
          div_step_r <= div_step_r + 1'b1;
          if (div_step_r == STEP_W'(DIV_W - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            out_err_r     <= err_val;
            out_cnt_r     <= div_den_r;
            out_lost_r    <= lost_nxt;
            out_restart_r <= restart_nxt;
            lost_r        <= lost_nxt;
            prev_err_r    <= prev_nxt;
            state_r       <= ST_ACC;
          end
        end
        default: begin
          state_r <= ST_ACC;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_error    = out_err_r;
  assign out_active_count  = out_cnt_r;
  assign out_lost_side     = $signed(out_lost_r);
  assign out_restart_timer = out_restart_r;

endmodule

// ===== rtl/line_position_estimator.sv =====
// Line position estimator: turns a scan of reflectance samples into one
// weighted-centroid line error per frame, with loss tracking.
// Depends on lpe_pkg, lpe_front, lpe_fifo, lpe_back and assert_macros.svh.
//
// Samples enter one per cycle while in_stall is low into a small queue
// (FIFO_DEPTH entries); the back end drains it one sample per cycle while
// accumulating and, on the frame-end sample, runs a shift-subtract divider
// when it has hits, then updates the loss state and loads the result
// register, taking no new sample meanwhile; in_stall rises on a full queue.
// The result register holds one finished frame while the next frame
// accumulates. Configuration is to be written through cfg_we/cfg_index/
// cfg_wdata by the user only while the block is idle; the block does not
// enforce this. Index 0 is the threshold, indexes 1 to 7 the magnitudes.
`include "assert_macros.svh"

module line_position_estimator #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpe_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [lpe_pkg::MAG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lpe_pkg::SAMPLE_W-1:0]        in_sample,
  input  logic [lpe_pkg::CHAN_W-1:0]          in_channel,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lpe_pkg::ERR_W-1:0]    out_line_error,
  output logic [lpe_pkg::CNT_W-1:0]           out_active_count,
  output logic signed [1:0]                   out_lost_side,
  output logic                                out_restart_timer
);

  lpe_pkg::cfg_t     cfg_r;
  lpe_pkg::q_entry_t q_wdata;
  lpe_pkg::q_entry_t q_rdata;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [2:0]        mag_wr_idx;

  assign mag_wr_idx = 3'(cfg_index - lpe_pkg::REG_MAG0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == lpe_pkg::REG_THRESHOLD) begin
        cfg_r.threshold <= cfg_wdata;
      end else begin
        cfg_r.mag[mag_wr_idx] <= cfg_wdata;
      end
    end
  end

  lpe_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_channel   (in_channel),
    .in_frame_end (in_frame_end),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  lpe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lpe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_error    (out_line_error),
    .out_active_count  (out_active_count),
    .out_lost_side     (out_lost_side),
    .out_restart_timer (out_restart_timer)
  );

  `LPE_ASSERT_IMPLY(a_nohit_zero, clk, rst_n, out_valid && (out_active_count == '0), (out_line_error == '0) && !out_restart_timer, "frame without hits must report zero error and no restart")
  `LPE_ASSERT_IMPLY(a_restart_on_line, clk, rst_n, out_valid && out_restart_timer, (out_lost_side == '0) && (out_active_count != '0), "restart pulse only on a reacquired frame")
  `LPE_ASSERT_IMPLY(a_lost_nohit, clk, rst_n, out_valid && (out_lost_side != '0), out_active_count == '0, "lost side reported on a frame with hits")

endmodule

// ===== test/tb_line_position_estimator.sv =====
// Self-checking bench for line_position_estimator: scans of sensor samples in,
// one centroid result per frame out, each checked against an in-bench model.
// Depends on lpe_pkg and the RTL of the block; reads no files.
module tb_line_position_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 4;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 48;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int NUM_PHASES      = 8;
  localparam int MAX_PRINTED     = 40;

  typedef struct {
    logic [lpe_pkg::SAMPLE_W-1:0] sample;
    logic [lpe_pkg::CHAN_W-1:0]   channel;
    logic                         frame_end;
  } sensor_sample_t;

  typedef struct {
    logic signed [lpe_pkg::ERR_W-1:0] line_error;
    logic [lpe_pkg::CNT_W-1:0]        active_count;
    logic signed [1:0]                lost_side;
    logic                             restart_timer;
  } frame_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [lpe_pkg::REG_IDX_W-1:0]       cfg_index = '0;
  logic [lpe_pkg::MAG_W-1:0]           cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [lpe_pkg::SAMPLE_W-1:0]        in_sample = '0;
  logic [lpe_pkg::CHAN_W-1:0]          in_channel = '0;
  logic                                in_frame_end = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [lpe_pkg::ERR_W-1:0]    out_line_error;
  logic [lpe_pkg::CNT_W-1:0]           out_active_count;
  logic signed [1:0]                   out_lost_side;
  logic                                out_restart_timer;

  sensor_sample_t pending_samples[$];
  frame_result_t  expected_frames[$];

  // Model copy of the registers and the frame state
  logic [lpe_pkg::SAMPLE_W-1:0] model_threshold;
  logic [lpe_pkg::MAG_W-1:0]    model_mag [lpe_pkg::HALF_SENSORS];
  int                           frame_weight_sum;
  int                           frame_hits;
  lpe_pkg::lost_t               model_lost;
  int                           model_prev_error;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;

  line_position_estimator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_channel        (in_channel),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_error    (out_line_error),
    .out_active_count  (out_active_count),
    .out_lost_side     (out_lost_side),
    .out_restart_timer (out_restart_timer)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Accumulate one sample; on frame end, queue the expected result
  function automatic void predict_centroid(input sensor_sample_t s);
    frame_result_t r;
    int            err;
    logic          restart;
    err = 0;
    restart = 1'b0;
    if (s.channel < lpe_pkg::NUM_SENSORS && s.sample > model_threshold &&
        frame_hits < int'(lpe_pkg::MAX_HITS)) begin
      if (s.channel < lpe_pkg::HALF_SENSORS)
        frame_weight_sum -= int'(model_mag[s.channel]);
      else
        frame_weight_sum += int'(model_mag[s.channel - lpe_pkg::HALF_SENSORS]);
      frame_hits++;
    end
    if (!s.frame_end) return;
    if (frame_hits != 0) begin
      err = frame_weight_sum / frame_hits;
      model_prev_error = err;
      // reacquired: preset to 6/5 of the edge weight on the lost side
      if (model_lost != lpe_pkg::LOST_NONE) begin
        restart = 1'b1;
        if (model_lost == lpe_pkg::LOST_NEG)
          model_prev_error = -(int'(model_mag[0]) * 6 / 5);
        else
          model_prev_error = int'(model_mag[lpe_pkg::HALF_SENSORS-1]) * 6 / 5;
      end
      model_lost = lpe_pkg::LOST_NONE;
    end else begin
      if (model_prev_error < -int'(model_mag[3])) model_lost = lpe_pkg::LOST_NEG;
      if (model_prev_error > int'(model_mag[1])) model_lost = lpe_pkg::LOST_POS;
    end
    r.line_error    = err[lpe_pkg::ERR_W-1:0];
    r.active_count  = frame_hits[lpe_pkg::CNT_W-1:0];
    r.lost_side     = model_lost;
    r.restart_timer = restart;
    expected_frames.push_back(r);
    frame_weight_sum = 0;
    frame_hits = 0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  // Sample driver
  always @(posedge clk) begin
    sensor_sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_centroid('{in_sample, in_channel, in_frame_end});
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_valid     <= 1'b1;
          in_sample    <= nxt.sample;
          in_channel   <= nxt.channel;
          in_frame_end <= nxt.frame_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result err=%0d count=%0d side=%0d restart=%0b",
                                  out_line_error, out_active_count, out_lost_side,
                                  out_restart_timer));
      end else begin
        exp_r = expected_frames.pop_front();
        if (out_line_error !== exp_r.line_error)
          report_mismatch($sformatf("line_error %0d, expected %0d",
                                    out_line_error, exp_r.line_error));
        if (out_active_count !== exp_r.active_count)
          report_mismatch($sformatf("active_count %0d, expected %0d",
                                    out_active_count, exp_r.active_count));
        if (out_lost_side !== exp_r.lost_side)
          report_mismatch($sformatf("lost_side %0d, expected %0d",
                                    out_lost_side, exp_r.lost_side));
        if (out_restart_timer !== exp_r.restart_timer)
          report_mismatch($sformatf("restart_timer %0b, expected %0b",
                                    out_restart_timer, exp_r.restart_timer));
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_token != hold_seen) || (hold_left > 1) ||
                 ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [lpe_pkg::REG_IDX_W-1:0] idx,
                           input logic [lpe_pkg::MAG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lpe_pkg::REG_THRESHOLD) model_threshold = val;
    else model_mag[idx - lpe_pkg::REG_MAG0] = val;
  endtask

  task automatic apply_settings(input logic [lpe_pkg::SAMPLE_W-1:0] thr,
                                input lpe_pkg::mag_arr_t m);
    write_reg(lpe_pkg::REG_THRESHOLD, thr);
    for (int i = 0; i < lpe_pkg::HALF_SENSORS; i++)
      write_reg(lpe_pkg::REG_IDX_W'(int'(lpe_pkg::REG_MAG0) + i), m[i]);
  endtask

  // Wait until the block has nothing in flight
  task automatic settle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void queue_item(input int s, input int c, input bit fe);
    pending_samples.push_back('{s[lpe_pkg::SAMPLE_W-1:0], c[lpe_pkg::CHAN_W-1:0], fe});
  endfunction

  function automatic int hi_level();
    if (model_threshold == {lpe_pkg::SAMPLE_W{1'b1}}) return 4095;
    return $urandom_range(4095, int'(model_threshold) + 1);
  endfunction

  function automatic int lo_level();
    return $urandom_range(int'(model_threshold), 0);
  endfunction

  // Full scan 0..13 with a line of random width; some scans see nothing
  function automatic int queue_scan();
    int center;
    int width;
    int roll;
    bit dark;
    roll  = $urandom_range(9, 0);
    dark  = (roll < 2);
    width = $urandom_range(2, 0);
    if (roll < 5)
      center = ($urandom_range(1, 0) != 0) ? $urandom_range(1, 0)
                                             : lpe_pkg::NUM_SENSORS - 1 - $urandom_range(1, 0);
    else
      center = $urandom_range(lpe_pkg::NUM_SENSORS - 1, 0);
    for (int ch = 0; ch < lpe_pkg::NUM_SENSORS; ch++)
      queue_item((!dark && ch >= center - width && ch <= center + width) ? hi_level()
                                                                          : lo_level(),
                 ch, ch == lpe_pkg::NUM_SENSORS - 1);
    return lpe_pkg::NUM_SENSORS;
  endfunction

  // Broken frames: random channels incl. invalid ones, or one channel hit repeatedly
  function automatic int queue_noise();
    int len;
    int ch;
    bit burst;
    len   = $urandom_range(20, 1);
    burst = ($urandom_range(3, 0) == 0);
    ch    = $urandom_range(15, 0);
    for (int k = 0; k < len; k++) begin
      if (burst)
        queue_item(hi_level(), ch, k == len - 1);
      else
        queue_item($urandom_range(4095, 0), $urandom_range(15, 0),
                   k == len - 1 || $urandom_range(15, 0) == 0);
    end
    return len;
  endfunction

  function automatic void queue_random(input int n);
    int made;
    made = 0;
    while (made < n)
      made += ($urandom_range(99, 0) < 75) ? queue_scan() : queue_noise();
  endfunction

  initial begin
    lpe_pkg::mag_arr_t            m;
    logic [lpe_pkg::SAMPLE_W-1:0] thr;
    frame_weight_sum = 0;
    frame_hits       = 0;
    model_lost       = lpe_pkg::LOST_NONE;
    model_prev_error = 0;
    model_threshold  = '0;
    for (int i = 0; i < lpe_pkg::HALF_SENSORS; i++) model_mag[i] = '0;
    wait (rst_n === 1'b1);

    // Directed: extremes, loss to each side, reacquisition, hit overflow
    m[0] = 12'd4095; m[1] = 12'd100;  m[2] = 12'd1500; m[3] = 12'd100;
    m[4] = 12'd2500; m[5] = 12'd3000; m[6] = 12'd4095;
    apply_settings(12'd100, m);
    @(negedge clk);
    queue_item(4095, 0, 1);
    queue_item(0, 5, 1);
    queue_item(4095, 13, 1);
    queue_item(4095, 14, 1);
    queue_item(4095, 15, 1);
    queue_item(4095, 7, 0);
    queue_item(100, 8, 0);
    queue_item(4095, 9, 1);
    queue_item(4095, 13, 1);
    queue_item(0, 0, 1);
    queue_item(4095, 0, 0);
    queue_item(4095, 8, 0);
    queue_item(4095, 9, 1);
    for (int k = 0; k < 16; k++) queue_item(4095, 13, k == 15);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      thr = lpe_pkg::SAMPLE_W'($urandom_range(3500, 200));
      for (int i = 0; i < lpe_pkg::HALF_SENSORS; i++) m[i] = lpe_pkg::MAG_W'($urandom);
      case (p)
        1: begin
          thr = '0;
          for (int i = 0; i < lpe_pkg::HALF_SENSORS; i++) m[i] = '1;
        end
        2: begin
          thr = '1;
          m = '0;
        end
        4: thr = lpe_pkg::SAMPLE_W'($urandom_range(40, 0));
        default: ;
      endcase
      apply_settings(thr, m);
      @(negedge clk);
      if (p == 5) begin
        // hold the sender until every result is back, then resume
        queue_random(ITEMS_PER_PHASE / 2);
        settle();
        queue_random(ITEMS_PER_PHASE / 2);
      end else begin
        queue_random(ITEMS_PER_PHASE);
      end
      // long receiver hold-off while samples keep coming
      if (p == 3) hold_token <= hold_token + 1;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
